// ===== hdl/lpbs_pkg.sv =====
// shared types and constants for the led priority blink selector
package lpbs_pkg;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_SET,
    OP_FLASH,
    OP_REFRESH
  } op_t;

  typedef enum logic [2:0] {
    MODE_OFF,
    MODE_ON,
    MODE_SLOW,
    MODE_FAST,
    MODE_FLASH
  } mode_t;

  // configuration register indexes
  localparam logic [2:0] REG_LED_ENABLE  = 3'd0;
  localparam logic [2:0] REG_BRIGHTNESS  = 3'd1;
  localparam logic [2:0] REG_FAST_PERIOD = 3'd2;
  localparam logic [2:0] REG_SLOW_PERIOD = 3'd3;
  localparam logic [2:0] REG_FLASH_TIME  = 3'd4;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 12;
  localparam int PERIOD_W   = 12;
  localparam int LEVEL_W    = 8;
  localparam int DUR_W      = 32;
  localparam int SCORE_W    = 6;
  localparam int CIDX_W     = 2;

  // physical channels with a pixel byte
  localparam int GRB_COLORS = 3;

  localparam logic [CIDX_W-1:0] COLOR_BLUE  = 2'd0;
  localparam logic [CIDX_W-1:0] COLOR_GREEN = 2'd1;
  localparam logic [CIDX_W-1:0] COLOR_RED   = 2'd2;
  localparam logic [CIDX_W-1:0] COLOR_NONE  = 2'd3;

  localparam logic [LEVEL_W-1:0]  RST_BRIGHTNESS  = 8'd80;
  localparam logic [PERIOD_W-1:0] RST_FAST_PERIOD = 12'd200;
  localparam logic [PERIOD_W-1:0] RST_SLOW_PERIOD = 12'd1000;
  localparam logic [PERIOD_W-1:0] RST_FLASH_TIME  = 12'd50;

  localparam logic [SCORE_W-1:0] MODE_WEIGHT = 6'd10;

endpackage

// ===== hdl/led_priority_blink_selector.sv =====
// top level: per-color mode state, tick/set/flash/refresh handling, priority pick
//
// Usage:
//   in_*  channel: one request per handshake. in_tuser carries the operation
//         (tick, set mode, flash request, refresh); in_tdata carries the color,
//         the requested mode and the duration in milliseconds.
//   out_* channel: a refresh request yields one result (winning color, its
//         score and the green, red and blue bytes); other requests yield none.
//   cfg_* port: single-cycle writes of enable, brightness, blink periods and
//         default flash time; write only while the block is idle.
// Timing: a request is held in the input register while its state update and
//   result are computed; a refresh result is then loaded into the result register
//   and shown on out_tvalid. One request per clock is taken, except while a
//   refresh is held in the input register by a stalled output.
// Stall: while out_tvalid is high and out_tready low the result holds; the
//   block keeps taking ticks, sets and flashes, and stops at the next refresh.
// Reset: rst_n low clears every color to off with no timeout and zero
//   counters, and loads the default configuration.
module led_priority_blink_selector
  import lpbs_pkg::*;
#(
  parameter int NUM_COLORS = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // cfg
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  // request stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [39:0]           in_tdata,  // color_sel[1:0], requested_mode[4:2],
                                           // duration[36:5], zero pad[39:37]
  input  logic [1:0]            in_tuser,  // operation[1:0]
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [31:0]           out_tdata  // shown_color[1:0], score[7:2],
                                           // green_level[15:8], red_level[23:16],
                                           // blue_level[31:24]
);

  localparam int LIT_COLORS = (NUM_COLORS < GRB_COLORS) ? NUM_COLORS : GRB_COLORS;

  // configuration
  logic                en_r;
  logic [LEVEL_W-1:0]  bright_r;
  logic [PERIOD_W-1:0] fast_per_r;
  logic [PERIOD_W-1:0] slow_per_r;
  logic [PERIOD_W-1:0] flash_time_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r         <= 1'b1;
      bright_r     <= RST_BRIGHTNESS;
      fast_per_r   <= RST_FAST_PERIOD;
      slow_per_r   <= RST_SLOW_PERIOD;
      flash_time_r <= RST_FLASH_TIME;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_LED_ENABLE:  en_r         <= cfg_wdata[0];
        REG_BRIGHTNESS:  bright_r     <= cfg_wdata[LEVEL_W-1:0];
        REG_FAST_PERIOD: fast_per_r   <= cfg_wdata[PERIOD_W-1:0];
        REG_SLOW_PERIOD: slow_per_r   <= cfg_wdata[PERIOD_W-1:0];
        REG_FLASH_TIME:  flash_time_r <= cfg_wdata[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic              s1_valid_r;
  op_t               s1_op_r;
  logic [CIDX_W-1:0] s1_color_r;
  logic [2:0]        s1_mode_r;
  logic [DUR_W-1:0]  s1_dur_r;
  logic              s1_advance;
  logic              in_acc;

  logic              out_valid_r;
  logic [31:0]       out_data_r;
  logic [31:0]       out_data_nxt;

  assign s1_advance = s1_valid_r && ((s1_op_r != OP_REFRESH) || !out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || s1_advance;
  assign in_acc     = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_op_r    <= op_t'(in_tuser);
      s1_color_r <= in_tdata[1:0];
      s1_mode_r  <= in_tdata[4:2];
      s1_dur_r   <= in_tdata[36:5];
    end
  end

  // per-color state
  mode_t               mode_r    [NUM_COLORS];
  logic [DUR_W-1:0]    tmo_r     [NUM_COLORS];
  logic [DUR_W-1:0]    elapsed_r [NUM_COLORS];
  logic [PERIOD_W-1:0] phase_r   [NUM_COLORS];
  mode_t               mode_nxt    [NUM_COLORS];
  logic [DUR_W-1:0]    tmo_nxt     [NUM_COLORS];
  logic [DUR_W-1:0]    elapsed_nxt [NUM_COLORS];
  logic [PERIOD_W-1:0] phase_nxt   [NUM_COLORS];

  mode_t               req_mode;
  logic                color_ok;
  logic [SCORE_W-1:0]  best;
  logic [CIDX_W-1:0]   shown;
  logic [LEVEL_W-1:0]  g_lvl, r_lvl, b_lvl;

  always_comb begin
    req_mode = (s1_mode_r > MODE_FLASH) ? MODE_OFF : mode_t'(s1_mode_r);
    color_ok = en_r && (int'(s1_color_r) < LIT_COLORS);
  end

  always_comb begin
    logic                is_blink;
    logic [PERIOD_W-1:0] per;
    logic [PERIOD_W:0]   p;
    logic                hit;
    logic                expired;
    mode_t               eff_mode;
    logic                lit;
    logic [SCORE_W-1:0]  sc;
    best  = '0;
    shown = COLOR_NONE;
    for (int i = 0; i < NUM_COLORS; i++) begin
      mode_nxt[i]    = mode_r[i];
      tmo_nxt[i]     = tmo_r[i];
      elapsed_nxt[i] = elapsed_r[i];
      phase_nxt[i]   = phase_r[i];
      is_blink = (mode_r[i] == MODE_SLOW) || (mode_r[i] == MODE_FAST);
      per      = (mode_r[i] == MODE_FAST) ? fast_per_r : slow_per_r;
      p        = {1'b0, phase_r[i]} + 1'b1;
      hit      = color_ok && (int'(s1_color_r) == i);
      expired  = en_r && (tmo_r[i] != '0) && (elapsed_r[i] >= tmo_r[i]);

      if (s1_valid_r && s1_advance) begin
        case (s1_op_r)
          OP_TICK: begin
            if (elapsed_r[i] != '1) elapsed_nxt[i] = elapsed_r[i] + 1'b1;
            if (is_blink) begin
              phase_nxt[i] = (p >= {1'b0, per}) ? '0 : p[PERIOD_W-1:0];
            end else begin
              phase_nxt[i] = '0;
            end
          end
          OP_SET: begin
            if (hit) begin
              mode_nxt[i]    = req_mode;
              tmo_nxt[i]     = ((req_mode == MODE_FLASH) && (s1_dur_r == '0)) ?
                               DUR_W'(flash_time_r) : s1_dur_r;
              elapsed_nxt[i] = '0;
              phase_nxt[i]   = '0;
            end
          end
          OP_FLASH: begin
            if (hit && !is_blink) begin
              mode_nxt[i]    = MODE_FLASH;
              tmo_nxt[i]     = DUR_W'(flash_time_r);
              elapsed_nxt[i] = '0;
              phase_nxt[i]   = '0;
            end
          end
          OP_REFRESH: begin
            if (expired) begin
              mode_nxt[i] = MODE_OFF;
              tmo_nxt[i]  = '0;
            end
          end
          default: ;
        endcase
      end

      // scoring uses the mode after expiry
      eff_mode = expired ? MODE_OFF : mode_r[i];
      lit = (eff_mode != MODE_OFF);
      if ((eff_mode == MODE_SLOW) || (eff_mode == MODE_FAST)) begin
        if (phase_r[i] >= (per >> 1)) lit = 1'b0;
      end
      sc = SCORE_W'(eff_mode) * MODE_WEIGHT + SCORE_W'(NUM_COLORS - i);
      if (en_r && lit && (i < GRB_COLORS) && (sc > best)) begin
        best  = sc;
        shown = CIDX_W'(i);
      end
    end

    g_lvl = (shown == COLOR_GREEN) ? bright_r : '0;
    r_lvl = (shown == COLOR_RED)   ? bright_r : '0;
    b_lvl = (shown == COLOR_BLUE)  ? bright_r : '0;
    out_data_nxt = {b_lvl, r_lvl, g_lvl, best, shown};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_COLORS; i++) begin
        mode_r[i]    <= MODE_OFF;
        tmo_r[i]     <= '0;
        elapsed_r[i] <= '0;
        phase_r[i]   <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_COLORS; i++) begin
        mode_r[i]    <= mode_nxt[i];
        tmo_r[i]     <= tmo_nxt[i];
        elapsed_r[i] <= elapsed_nxt[i];
        phase_r[i]   <= phase_nxt[i];
      end
    end
  end

  // result register
  logic load_out;
  assign load_out = s1_advance && (s1_op_r == OP_REFRESH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
